// ===== src/cfba_pkg.sv =====
// ----------------------------------------------------------------------------
// cfba_pkg
// shared types, constants and command codes of the chunked block allocator
// ----------------------------------------------------------------------------
package cfba_pkg;

   localparam int DEF_NUM_CHUNKS = 16;
   localparam int DEF_MAX_BLOCKS = 255;

   localparam int SLOT_PORT_W = 4;
   localparam int BLOCK_W     = 8;
   localparam int STATUS_W    = 2;

   localparam logic [BLOCK_W-1:0] BPC_RESET = 8'd64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   localparam int OP_W = 4;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_NOP       = 4'd0;
   localparam op_type OP_CAPTURE   = 4'd1;
   localparam op_type OP_ALLOC_SEL = 4'd2;
   localparam op_type OP_OPEN      = 4'd3;
   localparam op_type OP_FILL_STEP = 4'd4;
   localparam op_type OP_READ      = 4'd5;
   localparam op_type OP_ALLOC_FIN = 4'd6;
   localparam op_type OP_FULL      = 4'd7;
   localparam op_type OP_FREE_BAD  = 4'd8;
   localparam op_type OP_FREE_DO   = 4'd9;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic free_bad;
      logic alloc_hit;
      logic any_unused;
      logic fill_last;
   } dp_status_type;

endpackage

// ===== src/cfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfba_ctrl
// request sequencer: decides, fills fresh chunks, reads links, loads results
// ----------------------------------------------------------------------------
module cfba_ctrl
   import cfba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       load;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (status.is_free) begin
                  cmd.op   = status.free_bad ? OP_FREE_BAD : OP_FREE_DO;
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else if (status.alloc_hit) begin
                  cmd.op   = OP_ALLOC_SEL;
                  state_in = ST_FIN;
               end else if (status.any_unused) begin
                  cmd.op   = OP_OPEN;
                  state_in = ST_FILL;
               end else begin
                  cmd.op   = OP_FULL;
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            cmd.op = OP_FILL_STEP;
            if (status.fill_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_ALLOC_FIN;
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load)
      else $error("result register loaded while still held");

   a_read_then_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ALLOC_SEL || cmd.op == OP_READ) |=> (cmd.op == OP_ALLOC_FIN))
      else $error("link read not followed by allocate finish");

endmodule

// ===== src/cfba_dpath.sv =====
// ----------------------------------------------------------------------------
// cfba_dpath
// chunk table, free-list link memory, slot search and result register
// ----------------------------------------------------------------------------
module cfba_dpath
   import cfba_pkg::*;
#(
   parameter int NUM_CHUNKS = DEF_NUM_CHUNKS,
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [BLOCK_W-1:0]     csr_wr_data,
   input  logic                   req_cmd,
   input  logic [SLOT_PORT_W-1:0] req_slot,
   input  logic [BLOCK_W-1:0]     req_block,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_PORT_W-1:0] rsp_granted_slot,
   output logic [BLOCK_W-1:0]     rsp_granted_block,
   output logic                   rsp_chunk_released
);

   localparam int SLOT_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int ADDR_W    = SLOT_W + BLOCK_W;
   localparam int MEM_DEPTH = NUM_CHUNKS * (2 ** BLOCK_W);
   localparam logic [BLOCK_W-1:0] MAX_N = BLOCK_W'(MAX_BLOCKS);

   logic [BLOCK_W-1:0]    bpc_ff;
   logic [BLOCK_W-1:0]    n_eff;

   logic [NUM_CHUNKS-1:0] chunk_valid_ff;
   logic [BLOCK_W-1:0]    first_free_ff [NUM_CHUNKS];
   logic [BLOCK_W-1:0]    free_count_ff [NUM_CHUNKS];
   logic [SLOT_W-1:0]     cur_ff;
   logic                  cur_valid_ff;

   logic                  is_free_ff;
   logic                  slot_ok_ff;
   logic [BLOCK_W-1:0]    blk_ff;
   logic [SLOT_W-1:0]     sel_ff;
   logic [BLOCK_W-1:0]    fill_ff;

   logic [BLOCK_W-1:0]    link_mem [MEM_DEPTH];
   logic [BLOCK_W-1:0]    rdata_ff;

   logic [STATUS_W-1:0]   status_ff;
   logic [SLOT_PORT_W-1:0] gslot_ff;
   logic [BLOCK_W-1:0]    gblock_ff;
   logic                  released_ff;

   logic [NUM_CHUNKS-1:0] avail;
   logic [NUM_CHUNKS-1:0] keep_valid;
   logic [SLOT_W-1:0]     lo_avail;
   logic [SLOT_W-1:0]     lo_unused;
   logic [SLOT_W-1:0]     hi_valid;
   logic                  cur_ok;
   logic [SLOT_W-1:0]     sel_pick;
   logic [SLOT_W-1:0]     ff_raddr;
   logic [BLOCK_W-1:0]    ff_rd;
   logic [BLOCK_W-1:0]    cnt_rd;
   logic [BLOCK_W-1:0]    cnt_inc;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [BLOCK_W-1:0]    mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;

   always_comb begin
      if (bpc_ff == '0) begin
         n_eff = BLOCK_W'(1);
      end else if (bpc_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = bpc_ff;
      end
   end

   // slot search over the chunk flags
   always_comb begin
      lo_avail  = '0;
      lo_unused = '0;
      hi_valid  = '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
         avail[i]      = chunk_valid_ff[i] && (free_count_ff[i] != '0);
         keep_valid[i] = chunk_valid_ff[i] && (SLOT_W'(i) != sel_ff);
      end
      for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            lo_avail = SLOT_W'(i);
         end
         if (!chunk_valid_ff[i]) begin
            lo_unused = SLOT_W'(i);
         end
      end
      for (int i = 0; i < NUM_CHUNKS; i++) begin
         if (keep_valid[i]) begin
            hi_valid = SLOT_W'(i);
         end
      end
   end

   assign cur_ok   = cur_valid_ff && chunk_valid_ff[sel_ff] && (free_count_ff[sel_ff] != '0);
   assign sel_pick = cur_ok ? sel_ff : lo_avail;
   assign ff_raddr = (cmd.op == OP_ALLOC_SEL) ? sel_pick : sel_ff;
   assign ff_rd    = first_free_ff[ff_raddr];
   assign cnt_rd   = free_count_ff[sel_ff];
   assign cnt_inc  = cnt_rd + BLOCK_W'(1);

   assign status.is_free    = is_free_ff;
   assign status.free_bad   = !slot_ok_ff || !chunk_valid_ff[sel_ff] || (blk_ff >= n_eff)
                              || (cnt_rd >= n_eff);
   assign status.alloc_hit  = cur_ok || (avail != '0);
   assign status.any_unused = !(&chunk_valid_ff);
   assign status.fill_last  = (fill_ff == (n_eff - BLOCK_W'(1)));

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {sel_ff, fill_ff};
      mem_wdata = fill_ff + BLOCK_W'(1);
      mem_re    = 1'b0;
      mem_raddr = {sel_ff, ff_rd};
      case (cmd.op)
         OP_FILL_STEP: begin
            mem_we = 1'b1;
         end
         OP_FREE_DO: begin
            mem_we    = 1'b1;
            mem_waddr = {sel_ff, blk_ff};
            mem_wdata = ff_rd;
         end
         OP_ALLOC_SEL: begin
            mem_re    = 1'b1;
            mem_raddr = {sel_pick, ff_rd};
         end
         OP_READ: begin
            mem_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= link_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff         <= BPC_RESET;
         chunk_valid_ff <= '0;
         cur_ff         <= '0;
         cur_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CHUNKS; i++) begin
            first_free_ff[i] <= '0;
            free_count_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            bpc_ff <= csr_wr_data;
         end
         case (cmd.op)
            OP_ALLOC_SEL: begin
               cur_ff       <= sel_pick;
               cur_valid_ff <= 1'b1;
            end
            OP_OPEN: begin
               chunk_valid_ff[lo_unused] <= 1'b1;
               first_free_ff[lo_unused]  <= '0;
               free_count_ff[lo_unused]  <= n_eff;
               cur_ff                    <= lo_unused;
               cur_valid_ff              <= 1'b1;
            end
            OP_ALLOC_FIN: begin
               first_free_ff[sel_ff] <= rdata_ff;
               free_count_ff[sel_ff] <= cnt_rd - BLOCK_W'(1);
            end
            OP_FREE_DO: begin
               if (cnt_inc == n_eff) begin
                  chunk_valid_ff[sel_ff] <= 1'b0;
                  first_free_ff[sel_ff]  <= '0;
                  free_count_ff[sel_ff]  <= '0;
                  cur_ff                 <= hi_valid;
                  cur_valid_ff           <= (keep_valid != '0);
               end else begin
                  first_free_ff[sel_ff] <= blk_ff;
                  free_count_ff[sel_ff] <= cnt_inc;
                  cur_ff                <= sel_ff;
                  cur_valid_ff          <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // request capture, working slot, fill index and result register
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            is_free_ff <= (req_cmd == CMD_FREE);
            slot_ok_ff <= (int'(req_slot) < NUM_CHUNKS);
            blk_ff     <= req_block;
            sel_ff     <= (req_cmd == CMD_FREE) ? SLOT_W'(req_slot) : cur_ff;
         end
         OP_ALLOC_SEL: begin
            sel_ff <= sel_pick;
         end
         OP_OPEN: begin
            sel_ff  <= lo_unused;
            fill_ff <= '0;
         end
         OP_FILL_STEP: begin
            fill_ff <= fill_ff + BLOCK_W'(1);
         end
         OP_ALLOC_FIN: begin
            status_ff   <= STATUS_OK;
            gslot_ff    <= SLOT_PORT_W'(sel_ff);
            gblock_ff   <= ff_rd;
            released_ff <= 1'b0;
         end
         OP_FULL: begin
            status_ff   <= STATUS_FULL;
            gslot_ff    <= '0;
            gblock_ff   <= '0;
            released_ff <= 1'b0;
         end
         OP_FREE_BAD: begin
            status_ff   <= STATUS_BAD;
            gslot_ff    <= '0;
            gblock_ff   <= '0;
            released_ff <= 1'b0;
         end
         OP_FREE_DO: begin
            status_ff   <= STATUS_OK;
            gslot_ff    <= '0;
            gblock_ff   <= '0;
            released_ff <= (cnt_inc == n_eff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_slot   = gslot_ff;
   assign rsp_granted_block  = gblock_ff;
   assign rsp_chunk_released = released_ff;

   a_current_is_open: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> chunk_valid_ff[cur_ff])
      else $error("current chunk points at a closed slot");

   a_fill_open_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FILL_STEP) |-> chunk_valid_ff[sel_ff])
      else $error("link fill on a slot that is not open");

endmodule

// ===== src/chunked_fixed_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// chunked_fixed_block_allocator_core
// fixed-size block pool built from chunk slots with embedded free lists
// ----------------------------------------------------------------------------
// One request in flight at a time; the result sits in an output register, so
// the next request is taken while it waits and decided once that register is
// free. A free loads its result from decide; an allocate from an open chunk
// selects the slot with a registered link memory read, then finishes. An
// allocate that opens a fresh chunk first writes the link memory one entry per
// cycle to build the new free list of n entries, n being the effective blocks
// per chunk, then reads. Slot search is a priority encode over per-slot flags.
module chunked_fixed_block_allocator_core
   import cfba_pkg::*;
#(
   parameter int NUM_CHUNKS = DEF_NUM_CHUNKS,
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [BLOCK_W-1:0]     csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [SLOT_PORT_W-1:0] req_slot,
   input  logic [BLOCK_W-1:0]     req_block,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_PORT_W-1:0] rsp_granted_slot,
   output logic [BLOCK_W-1:0]     rsp_granted_block,
   output logic                   rsp_chunk_released
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfba_dpath #(
      .NUM_CHUNKS (NUM_CHUNKS),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_block          (req_block),
      .cmd                (cmd),
      .status             (status),
      .rsp_status         (rsp_status),
      .rsp_granted_slot   (rsp_granted_slot),
      .rsp_granted_block  (rsp_granted_block),
      .rsp_chunk_released (rsp_chunk_released)
   );

endmodule
